// File: hdl/ppfi_pkg.sv
// Shared types, constants and helper functions of the path prune first index unit.
`default_nettype none
package ppfi_pkg;

	localparam int MAX_TRAJ  = 64;
	localparam int TRAJ_AW   = $clog2(MAX_TRAJ);
	localparam int TC_W      = $clog2(MAX_TRAJ + 1);
	localparam int MAX_PATH  = 1024;
	localparam int PATH_AW   = $clog2(MAX_PATH);
	localparam int PC_W      = $clog2(MAX_PATH + 1);

	localparam int POS_W     = 32;
	localparam int HDG_W     = 20;
	localparam int DIF_W     = POS_W + 1;
	localparam int TRIG_W    = 20;
	localparam int LEN_W     = DIF_W + 1;
	localparam int LOOK_W    = LEN_W;
	localparam int ACC_W     = 46;
	localparam int PROD_W    = DIF_W + TRIG_W;
	localparam int IDX_W     = 11;
	localparam int OP_W      = 2;
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 16;

	localparam logic [OP_W-1:0] OP_LOAD_TRAJ = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_PATH = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN       = 2'd2;

	localparam logic [31:0] LOOK_RESET = 32'd196608;

	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam logic signed [20:0] Q16_PI      = 21'sd205887;
	localparam logic signed [20:0] Q16_TWO_PI  = 21'sd411775;
	localparam logic signed [20:0] Q16_HALF_PI = 21'sd102944;
	localparam logic signed [TRIG_W-1:0] CORDIC_INV_GAIN = 20'sd39797;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic signed [TRIG_W-1:0] sn;
		logic signed [TRIG_W-1:0] cs;
	} cordic_res_t;

	typedef struct packed {
		logic le0;
		logic ge0;
	} proj_flags_t;

	// rounded Q16 atan(2^-k)
	function automatic logic signed [TRIG_W-1:0] atan_q16(input logic [STEP_W-1:0] k);
		logic signed [TRIG_W-1:0] r;
		case (k)
			4'd0:    r = 20'sd51472;
			4'd1:    r = 20'sd30385;
			4'd2:    r = 20'sd16055;
			4'd3:    r = 20'sd8150;
			4'd4:    r = 20'sd4091;
			4'd5:    r = 20'sd2047;
			4'd6:    r = 20'sd1024;
			4'd7:    r = 20'sd512;
			4'd8:    r = 20'sd256;
			4'd9:    r = 20'sd128;
			4'd10:   r = 20'sd64;
			4'd11:   r = 20'sd32;
			4'd12:   r = 20'sd16;
			4'd13:   r = 20'sd8;
			4'd14:   r = 20'sd4;
			4'd15:   r = 20'sd2;
			default: r = 20'sd0;
		endcase
		return r;
	endfunction

	function automatic logic [DIF_W-1:0] mag(input logic signed [DIF_W-1:0] v);
		return v[DIF_W-1] ? DIF_W'(-v) : DIF_W'(v);
	endfunction

endpackage
`default_nettype wire

// File: hdl/ppfi_cordic.sv
// Iterative rotation-mode CORDIC: sin and cos of a Q3.16 heading, one step per cycle.
`default_nettype none
module ppfi_cordic (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      go,
	input  wire logic signed [ppfi_pkg::HDG_W-1:0]   angle,
	input  wire                                      reverse,
	output ppfi_pkg::cordic_res_t                    res
);
	logic                                  busy_q, done_q, neg_q;
	logic [ppfi_pkg::STEP_W-1:0]           k_q;
	logic signed [ppfi_pkg::TRIG_W-1:0]    x_q, y_q, z_q;
	logic signed [20:0]                    zw, zf;
	logic                                  fold;
	logic signed [ppfi_pkg::TRIG_W-1:0]    xs, ys, at;

	always_comb begin
		zw = 21'(angle);
		if (zw > ppfi_pkg::Q16_PI) begin
			zw = zw - ppfi_pkg::Q16_TWO_PI;
		end else if (zw < -ppfi_pkg::Q16_PI) begin
			zw = zw + ppfi_pkg::Q16_TWO_PI;
		end
		fold = 1'b0;
		zf = zw;
		if (zw > ppfi_pkg::Q16_HALF_PI) begin
			zf = zw - ppfi_pkg::Q16_PI;
			fold = 1'b1;
		end else if (zw < -ppfi_pkg::Q16_HALF_PI) begin
			zf = zw + ppfi_pkg::Q16_PI;
			fold = 1'b1;
		end
		xs = x_q >>> k_q;
		ys = y_q >>> k_q;
		at = ppfi_pkg::atan_q16(k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && k_q == ppfi_pkg::STEP_W'(ppfi_pkg::CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !busy_q) begin
			x_q   <= ppfi_pkg::CORDIC_INV_GAIN;
			y_q   <= '0;
			z_q   <= zf[ppfi_pkg::TRIG_W-1:0];
			k_q   <= '0;
			neg_q <= fold ^ reverse;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			k_q <= k_q + 1'b1;
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.cs   = neg_q ? -x_q : x_q;
	assign res.sn   = neg_q ? -y_q : y_q;
endmodule
`default_nettype wire

// File: hdl/ppfi_proj.sv
// Projection sign unit: registered products of an offset with cos/sin, then sign of the sum.
`default_nettype none
module ppfi_proj (
	input  wire                                      clk,
	input  wire logic signed [ppfi_pkg::DIF_W-1:0]   dx,
	input  wire logic signed [ppfi_pkg::DIF_W-1:0]   dy,
	input  wire logic signed [ppfi_pkg::TRIG_W-1:0]  cs,
	input  wire logic signed [ppfi_pkg::TRIG_W-1:0]  sn,
	output ppfi_pkg::proj_flags_t                    flags
);
	logic signed [ppfi_pkg::PROD_W-1:0] p1_s1, p2_s1;
	logic signed [ppfi_pkg::PROD_W:0]   sum;

	always_ff @(posedge clk) begin
		p1_s1 <= dx * cs;
		p2_s1 <= dy * sn;
	end

	assign sum       = (ppfi_pkg::PROD_W+1)'(p1_s1) + (ppfi_pkg::PROD_W+1)'(p2_s1);
	assign flags.le0 = sum[ppfi_pkg::PROD_W] || (sum == '0);
	assign flags.ge0 = !sum[ppfi_pkg::PROD_W];
endmodule
`default_nettype wire

// File: hdl/path_prune_first_index_unit.sv
// Top level: load memories, turning test, CORDIC and path walk sequencer.
//
// Usage: requests enter on the s_ channel; s_tuser carries the op code.
//   op 0 stores a trajectory pose (x, y, heading), op 1 stores a path point
//   (x, y); each load yields no result. A full memory
//   drops the load. op 2 runs the search and yields one m_ result, the index
//   of the first path point to keep; both counts clear when it is issued.
//   op 3 is ignored.
// A run does the turning test over the trajectory poses, then the CORDIC,
//   then the outer walk over the path points with a look-ahead over later
//   points, and then issues the result; the single read port of the path
//   memory and the registered multiplier set its pace.
//   s_tready is high only while the sequencer is idle: loads flow one per
//   cycle, a run holds the input until its result is registered.
// Stall: a result waits in the m_ output register; further loads are taken
//   meanwhile, and a following run finishes its walk and then waits for
//   that register to drain.
// Reset: counts clear, lookahead_limit returns to 3.0 m (196608); memory
//   contents are not cleared, entries are read only after being written.
// cfg_we/cfg_wdata write lookahead_limit; write only while idle.
`default_nettype none
module path_prune_first_index_unit (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire [31:0]                             cfg_wdata,
	input  wire                                    s_tvalid,
	output logic                                   s_tready,
	// pos_x[31:0], pos_y[63:32], heading[83:64], moving_forward[84], zero pad
	input  wire [ppfi_pkg::IN_TDATA_W-1:0]         s_tdata,
	// op[1:0]
	input  wire [ppfi_pkg::OP_W-1:0]               s_tuser,
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	// first_kept_index[10:0], zero pad
	output logic [ppfi_pkg::OUT_TDATA_W-1:0]       m_tdata
);
	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE = 5'd0,  ST_T0  = 5'd1,  ST_TCHK = 5'd2,
		ST_TDAT = 5'd3,  ST_TTST = 5'd4,  ST_CGO = 5'd5,  ST_CORD = 5'd6,
		ST_RDI  = 5'd7,  ST_PI   = 5'd8,  ST_PIM = 5'd9,  ST_PIC  = 5'd10,
		ST_PN   = 5'd11, ST_PNM  = 5'd12, ST_PNC = 5'd13, ST_IA   = 5'd14,
		ST_IAM  = 5'd15, ST_IB   = 5'd16, ST_ID  = 5'd17, ST_IE   = 5'd18,
		ST_IR   = 5'd19, ST_DONE = 5'd20;

	localparam int TW = 2 * ppfi_pkg::POS_W + ppfi_pkg::HDG_W;
	localparam int PW = 2 * ppfi_pkg::POS_W;

	// storage
	logic [TW-1:0] traj_mem [ppfi_pkg::MAX_TRAJ];
	logic [PW-1:0] path_mem [ppfi_pkg::MAX_PATH];
	logic [ppfi_pkg::TRAJ_AW-1:0] traj_raddr;
	logic [ppfi_pkg::PATH_AW-1:0] path_raddr;
	logic [TW-1:0] traj_rd_q;
	logic [PW-1:0] path_rd_q;

	logic [ST_W-1:0]              state_q;
	logic [ppfi_pkg::TC_W-1:0]    tc_q, t_q;
	logic [ppfi_pkg::PC_W-1:0]    pc_q;
	logic [31:0]                  limit_q;
	logic                         m_valid_q;
	logic [ppfi_pkg::IDX_W-1:0]   m_idx_q, res_q;
	logic                         fwd_q, rot_q, farther_q;
	logic [ppfi_pkg::LOOK_W-1:0]  look_q, mlen_q, len_q;
	logic [ppfi_pkg::HDG_W:0]     mth_q, dth_q;
	logic [ppfi_pkg::ACC_W-1:0]   glen_q, dist_q;
	logic [ppfi_pkg::IDX_W-1:0]   i_q, c_q, far_q, last_q;
	logic signed [ppfi_pkg::POS_W-1:0] x0_q, y0_q, pix_q, piy_q, cx_q, cy_q, qx_q, qy_q;
	logic signed [ppfi_pkg::HDG_W-1:0] th0_q;
	logic signed [ppfi_pkg::DIF_W-1:0] dx_q, dy_q;
	logic signed [ppfi_pkg::TRIG_W-1:0] cs_q, sn_q;

	logic accept, cordic_go;
	ppfi_pkg::cordic_res_t cres;
	ppfi_pkg::proj_flags_t pf;

	logic signed [ppfi_pkg::POS_W-1:0] tr_x, tr_y, pr_x, pr_y;
	logic signed [ppfi_pkg::HDG_W-1:0] tr_h;
	logic [ppfi_pkg::LOOK_W-1:0]  mlen_n;
	logic [ppfi_pkg::HDG_W:0]     mth_n;
	logic [ppfi_pkg::LOOK_W+3:0]  ten_mlen;
	logic [ppfi_pkg::IDX_W-1:0]   i_p1, c_p1;
	logic [ppfi_pkg::LEN_W-1:0]   gstep, dstep;
	logic signed [ppfi_pkg::DIF_W-1:0] gx, gy;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = ppfi_pkg::OUT_TDATA_W'(m_idx_q);

	assign tr_x = traj_rd_q[31:0];
	assign tr_y = traj_rd_q[63:32];
	assign tr_h = traj_rd_q[TW-1:64];
	assign pr_x = path_rd_q[31:0];
	assign pr_y = path_rd_q[63:32];
	assign i_p1 = i_q + 1'b1;
	assign c_p1 = c_q + 1'b1;

	// running maxima of the turning test; 10*mlen as shift-add
	assign mlen_n   = (len_q > mlen_q) ? len_q : mlen_q;
	assign mth_n    = (dth_q > mth_q) ? dth_q : mth_q;
	assign ten_mlen = ((ppfi_pkg::LOOK_W+4)'(mlen_n) << 3) + ((ppfi_pkg::LOOK_W+4)'(mlen_n) << 1);

	assign gx    = ppfi_pkg::DIF_W'(pr_x) - ppfi_pkg::DIF_W'(pix_q);
	assign gy    = ppfi_pkg::DIF_W'(pr_y) - ppfi_pkg::DIF_W'(piy_q);
	assign gstep = ppfi_pkg::LEN_W'(ppfi_pkg::mag(gx)) + ppfi_pkg::LEN_W'(ppfi_pkg::mag(gy));
	assign dstep = ppfi_pkg::LEN_W'(ppfi_pkg::mag(ppfi_pkg::DIF_W'(cx_q) - ppfi_pkg::DIF_W'(qx_q)))
		+ ppfi_pkg::LEN_W'(ppfi_pkg::mag(ppfi_pkg::DIF_W'(cy_q) - ppfi_pkg::DIF_W'(qy_q)));

	assign cordic_go = (state_q == ST_CGO);

	always_comb begin
		traj_raddr = (state_q == ST_TCHK) ? t_q[ppfi_pkg::TRAJ_AW-1:0] : '0;
		case (state_q)
			ST_PIC:  path_raddr = i_p1[ppfi_pkg::PATH_AW-1:0];
			ST_IE:   path_raddr = c_p1[ppfi_pkg::PATH_AW-1:0];
			default: path_raddr = i_q[ppfi_pkg::PATH_AW-1:0];
		endcase
	end

	// memories: writes only from idle loads, one registered read each
	always_ff @(posedge clk) begin
		if (accept && s_tuser == ppfi_pkg::OP_LOAD_TRAJ &&
		    tc_q < ppfi_pkg::TC_W'(ppfi_pkg::MAX_TRAJ)) begin
			traj_mem[tc_q[ppfi_pkg::TRAJ_AW-1:0]] <= s_tdata[TW-1:0];
		end
		if (accept && s_tuser == ppfi_pkg::OP_LOAD_PATH &&
		    pc_q < ppfi_pkg::PC_W'(ppfi_pkg::MAX_PATH)) begin
			path_mem[pc_q[ppfi_pkg::PATH_AW-1:0]] <= s_tdata[PW-1:0];
		end
		traj_rd_q <= traj_mem[traj_raddr];
		path_rd_q <= path_mem[path_raddr];
	end

	ppfi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cordic_go),
		.angle   (th0_q),
		.reverse (!fwd_q),
		.res     (cres)
	);

	ppfi_proj u_proj (
		.clk   (clk),
		.dx    (dx_q),
		.dy    (dy_q),
		.cs    (cs_q),
		.sn    (sn_q),
		.flags (pf)
	);

	// control: state, counts, register, output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tc_q      <= '0;
			pc_q      <= '0;
			limit_q   <= ppfi_pkg::LOOK_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			// ST_DONE owns the slot while it issues
			if (m_valid_q && m_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == ppfi_pkg::OP_LOAD_TRAJ) begin
							if (tc_q < ppfi_pkg::TC_W'(ppfi_pkg::MAX_TRAJ)) tc_q <= tc_q + 1'b1;
						end else if (s_tuser == ppfi_pkg::OP_LOAD_PATH) begin
							if (pc_q < ppfi_pkg::PC_W'(ppfi_pkg::MAX_PATH)) pc_q <= pc_q + 1'b1;
						end else if (s_tuser == ppfi_pkg::OP_RUN) begin
							state_q <= (tc_q == '0) ? ST_DONE : ST_T0;
						end
					end
				end
				ST_T0:   state_q <= ST_TCHK;
				ST_TCHK: state_q <= (t_q >= tc_q) ? ST_CGO : ST_TDAT;
				ST_TDAT: state_q <= ST_TTST;
				ST_TTST: begin
					if (mlen_n == '0 || (ppfi_pkg::LOOK_W+4)'(mth_n) > ten_mlen ||
					    ppfi_pkg::LOOK_W'(mth_n) < mlen_n) begin
						state_q <= ST_CGO;
					end else begin
						state_q <= ST_TCHK;
					end
				end
				ST_CGO:  state_q <= ST_CORD;
				ST_CORD: if (cres.done) state_q <= ST_RDI;
				ST_RDI:  state_q <= (ppfi_pkg::PC_W'(i_q) >= pc_q) ? ST_DONE : ST_PI;
				ST_PI:   state_q <= ST_PIM;
				ST_PIM:  state_q <= ST_PIC;
				ST_PIC: begin
					if (pf.le0 || ppfi_pkg::PC_W'(i_p1) == pc_q) state_q <= ST_DONE;
					else state_q <= ST_PN;
				end
				ST_PN:   state_q <= ST_PNM;
				ST_PNM:  state_q <= ST_PNC;
				ST_PNC: begin
					if (rot_q && glen_q > ppfi_pkg::ACC_W'(look_q)) state_q <= ST_DONE;
					else if (pf.ge0 || (farther_q && i_q <= far_q)) state_q <= ST_RDI;
					else state_q <= ST_IA;
				end
				ST_IA:   state_q <= (c_q >= last_q) ? ST_IAM : ST_ID;
				ST_IAM:  state_q <= ST_IB;
				ST_IB:   state_q <= pf.le0 ? ST_RDI : ST_ID;
				ST_ID:   state_q <= ST_IE;
				ST_IE: begin
					if (dist_q > ppfi_pkg::ACC_W'(look_q) || ppfi_pkg::PC_W'(c_p1) >= pc_q)
						state_q <= ST_DONE;
					else
						state_q <= ST_IR;
				end
				ST_IR:   state_q <= ST_IA;
				ST_DONE: begin
					// issue result once the output slot is free; counts clear per run
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						tc_q      <= '0;
						pc_q      <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of the search
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				fwd_q     <= s_tdata[84];
				look_q    <= ppfi_pkg::LOOK_W'(limit_q);
				rot_q     <= 1'b0;
				farther_q <= 1'b0;
				mlen_q    <= '0;
				mth_q     <= '0;
				glen_q    <= '0;
				i_q       <= '0;
				far_q     <= '0;
				last_q    <= '0;
				res_q     <= '0;
				t_q       <= ppfi_pkg::TC_W'(1);
			end
			ST_T0: begin
				x0_q  <= tr_x;
				y0_q  <= tr_y;
				th0_q <= tr_h;
			end
			ST_TDAT: begin
				len_q <= ppfi_pkg::LEN_W'(ppfi_pkg::mag(ppfi_pkg::DIF_W'(tr_x) - ppfi_pkg::DIF_W'(x0_q)))
					+ ppfi_pkg::LEN_W'(ppfi_pkg::mag(ppfi_pkg::DIF_W'(tr_y) - ppfi_pkg::DIF_W'(y0_q)));
				dth_q <= (ppfi_pkg::HDG_W+1)'(ppfi_pkg::mag(ppfi_pkg::DIF_W'(tr_h) - ppfi_pkg::DIF_W'(th0_q)));
			end
			ST_TTST: begin
				mlen_q <= mlen_n;
				mth_q  <= mth_n;
				t_q    <= t_q + 1'b1;
				if (mlen_n == '0) begin
					look_q <= '0;
					rot_q  <= 1'b1;
				end else if ((ppfi_pkg::LOOK_W+4)'(mth_n) > ten_mlen) begin
					look_q <= mlen_n;
					rot_q  <= 1'b1;
				end
			end
			ST_CORD: begin
				cs_q <= cres.cs;
				sn_q <= cres.sn;
			end
			ST_RDI: res_q <= i_q;
			ST_PI: begin
				pix_q <= pr_x;
				piy_q <= pr_y;
				dx_q  <= ppfi_pkg::DIF_W'(x0_q) - ppfi_pkg::DIF_W'(pr_x);
				dy_q  <= ppfi_pkg::DIF_W'(y0_q) - ppfi_pkg::DIF_W'(pr_y);
			end
			// last point passed: it is dropped too
			ST_PIC: if (!pf.le0 && ppfi_pkg::PC_W'(i_p1) == pc_q) res_q <= i_p1;
			ST_PN: begin
				cx_q <= pr_x;
				cy_q <= pr_y;
				dx_q <= gx;
				dy_q <= gy;
				if (rot_q) glen_q <= glen_q + ppfi_pkg::ACC_W'(gstep);
			end
			ST_PNC: begin
				if (!(rot_q && glen_q > ppfi_pkg::ACC_W'(look_q))) begin
					if (pf.ge0 || (farther_q && i_q <= far_q)) begin
						i_q <= i_p1;
					end else begin
						farther_q <= 1'b0;
						c_q       <= i_p1;
						dist_q    <= '0;
						qx_q      <= pix_q;
						qy_q      <= piy_q;
					end
				end
			end
			ST_IA: begin
				dx_q <= ppfi_pkg::DIF_W'(x0_q) - ppfi_pkg::DIF_W'(cx_q);
				dy_q <= ppfi_pkg::DIF_W'(y0_q) - ppfi_pkg::DIF_W'(cy_q);
			end
			ST_IB: begin
				if (pf.le0) begin
					farther_q <= 1'b1;
					far_q     <= c_q;
					last_q    <= c_q;
					i_q       <= i_p1;
				end
			end
			ST_ID: dist_q <= dist_q + ppfi_pkg::ACC_W'(dstep);
			ST_IE: begin
				if (dist_q > ppfi_pkg::ACC_W'(look_q)) last_q <= c_q;
				else if (ppfi_pkg::PC_W'(c_p1) >= pc_q) last_q <= c_p1;
				else c_q <= c_p1;
			end
			ST_IR: begin
				qx_q <= cx_q;
				qy_q <= cy_q;
				cx_q <= pr_x;
				cy_q <= pr_y;
			end
			ST_DONE: if (!m_valid_q || m_tready) m_idx_q <= res_q;
			default: ;
		endcase
	end

	// the walk index never passes the path count
	a_i_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_DONE && state_q != ST_T0) |->
		ppfi_pkg::PC_W'(i_q) <= pc_q)
		else $error("walk index beyond path count");

	// look-ahead reads stay inside the loaded path
	a_c_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IA) |-> ppfi_pkg::PC_W'(c_q) < pc_q)
		else $error("look-ahead index beyond path count");

	// CORDIC is only started when idle
	a_cordic_go: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_go |-> !cres.busy)
		else $error("CORDIC restarted while busy");

	// issuing a result clears both counts
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!m_valid_q || m_tready)) |=>
		(m_valid_q && tc_q == '0 && pc_q == '0))
		else $error("result issue did not clear counts");

	// a load into a full path memory leaves the count alone
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == ppfi_pkg::OP_LOAD_PATH &&
		 pc_q == ppfi_pkg::PC_W'(ppfi_pkg::MAX_PATH)) |=> $stable(pc_q))
		else $error("full path memory count changed");
endmodule
`default_nettype wire
